FILE: src/pmo_pkg.sv
// Shared types, constants and the gray conversion for the opened pixel mask.
// Used by every module of pixel_mask_with_opening_unit; depends on nothing.
package pmo_pkg;

   localparam int MaxWidth  = 256;
   localparam int MaxHeight = 256;
   localparam int ColBits   = $clog2(MaxWidth);
   localparam int DimBits   = $clog2(MaxHeight) + 1;
   localparam int RowBits   = $clog2(MaxHeight + 2) + 1;
   localparam int CsrBits   = 9;
   localparam int CsrIdxBits = 3;
   localparam int FifoDepth = 4;
   localparam int FifoPtrBits = $clog2(FifoDepth);
   localparam int FifoCntBits = $clog2(FifoDepth) + 1;

   localparam logic [DimBits-1:0] WidthReset  = DimBits'(206);
   localparam logic [DimBits-1:0] HeightReset = DimBits'(156);
   localparam logic [7:0]         DiffReset   = 8'd5;
   localparam logic [7:0]         BrightReset = 8'd200;

   localparam logic [22:0] WeightRed   = 23'd4899;
   localparam logic [22:0] WeightGreen = 23'd9617;
   localparam logic [22:0] WeightBlue  = 23'd1868;
   localparam logic [22:0] GrayRound   = 23'd8192;

   typedef enum logic [CsrIdxBits-1:0] {
      RegWidth  = 3'd0,
      RegHeight = 3'd1,
      RegMode   = 3'd2,
      RegDiff   = 3'd3,
      RegBright = 3'd4
   } pmo_reg_type;

   typedef enum logic [1:0] {
      ModeDrop   = 2'd0,
      ModeBright = 2'd1,
      ModeGated  = 2'd2
   } pmo_mode_type;

   typedef struct packed {
      logic [7:0] cur_red;
      logic [7:0] cur_green;
      logic [7:0] cur_blue;
      logic [7:0] prev_red;
      logic [7:0] prev_green;
      logic [7:0] prev_blue;
      logic       motion_gate;
   } pmo_pixel_type;

   typedef struct packed {
      logic               vld;
      logic [RowBits-1:0] row;
      logic [ColBits-1:0] col;
      logic [ColBits-1:0] nxt;
   } pmo_pos_type;

   typedef struct packed {
      logic raw_up;
      logic raw_lo;
      logic ero_up;
      logic ero_lo;
   } pmo_entry_type;

   typedef struct packed {
      logic               vld;
      logic               mask_on;
      logic [7:0]         out_row;
      logic [7:0]         out_col;
      logic               frame_last;
   } pmo_result_type;

   function automatic logic [7:0] pmo_gray(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [22:0] sum;
      sum = 23'(r) * WeightRed + 23'(g) * WeightGreen + 23'(b) * WeightBlue + GrayRound;
      return sum[21:14];
   endfunction

endpackage

FILE: src/pixel_mask_with_opening_unit.sv
// Opened pixel mask: one request per clock while req_tready is high, raw mask,
// erosion and dilation with a 3x3 cross through a two-row line memory, result two
// rows behind the input. Depends on pmo_pkg, pmo_raw_mask, pmo_morph and pmo_out_fifo.
//
// While req_tready is high the block takes one pixel request every clock and returns
// the opened mask bit of the pixel two rows above it, in raster order; the first two
// rows of a frame give no response and two rows of pad requests flush the last two.
// The rate is set by the single line memory, which is read and written once per
// clock with a forwarding path between the two. Pad requests within the image rows
// are dropped. Configure only while idle.
module pixel_mask_with_opening_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cur_red, cur_green, cur_blue, prev_red, prev_green, prev_blue, motion_gate, zero fill
   input  logic [55:0] req_tdata,
   // is_pad
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mask_on, out_row, out_col, zero fill
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic                              csr_we,
   input  logic [pmo_pkg::CsrIdxBits-1:0]    csr_index,
   input  logic [pmo_pkg::CsrBits-1:0]       csr_wdata
);
   import pmo_pkg::*;

   logic [DimBits-1:0] width_ff;
   logic [DimBits-1:0] height_ff;
   logic [1:0]         mode_ff;
   logic [7:0]         diff_ff;
   logic [7:0]         bright_ff;

   logic [RowBits-1:0] row_ff;
   logic [RowBits-1:0] row_in;
   logic [ColBits-1:0] col_ff;
   logic [ColBits-1:0] col_in;

   pmo_pos_type   s1_ff;
   pmo_pos_type   s1_in;
   pmo_pixel_type pix_ff;
   pmo_pixel_type pix_in;

   logic [DimBits-1:0] width;
   logic [DimBits-1:0] height;
   logic [RowBits-1:0] rows_total;
   logic [RowBits-1:0] row_eff;
   logic [ColBits-1:0] col_eff;
   logic [DimBits-1:0] col_next;
   logic [RowBits-1:0] row_next;
   logic               accept;
   logic               in_frame_eff;
   logic               s1_in_frame;
   logic               s1_raw;
   logic               s2_busy;
   logic [FifoCntBits-1:0] fifo_cnt;
   logic [FifoCntBits-1:0] occupancy;
   pmo_result_type     result;
   pmo_result_type     head;

   always_comb begin
      width = width_ff;
      if (width_ff == '0) width = DimBits'(1);
      else if (width_ff > DimBits'(MaxWidth)) width = DimBits'(MaxWidth);
      height = height_ff;
      if (height_ff == '0) height = DimBits'(1);
      else if (height_ff > DimBits'(MaxHeight)) height = DimBits'(MaxHeight);
      rows_total = RowBits'(height) + RowBits'(2);

      occupancy  = fifo_cnt + FifoCntBits'(s1_ff.vld) + FifoCntBits'(s2_busy);
      req_tready = occupancy < FifoCntBits'(FifoDepth);
      accept     = req_tvalid && req_tready;

      // restart the frame when the position lies outside it
      row_eff = row_ff;
      col_eff = col_ff;
      if (({1'b0, col_ff} >= width) || (row_ff >= rows_total)) begin
         row_eff = '0;
         col_eff = '0;
      end
      in_frame_eff = row_eff < RowBits'(height);

      col_next = {1'b0, col_eff} + 1'b1;
      row_next = row_eff + 1'b1;

      s1_in.vld = accept && !(in_frame_eff && req_tuser);
      s1_in.row = row_eff;
      s1_in.col = col_eff;
      s1_in.nxt = (col_next < width) ? col_next[ColBits-1:0] : '0;

      row_in = row_eff;
      col_in = col_eff;
      if (s1_in.vld) begin
         if (col_next < width) begin
            col_in = col_next[ColBits-1:0];
         end else begin
            col_in = '0;
            row_in = (row_next >= rows_total) ? '0 : row_next;
         end
      end

      pix_in.cur_red     = req_tdata[7:0];
      pix_in.cur_green   = req_tdata[15:8];
      pix_in.cur_blue    = req_tdata[23:16];
      pix_in.prev_red    = req_tdata[31:24];
      pix_in.prev_green  = req_tdata[39:32];
      pix_in.prev_blue   = req_tdata[47:40];
      pix_in.motion_gate = req_tdata[48];

      s1_in_frame = s1_ff.row < RowBits'(height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
         mode_ff   <= 2'(ModeDrop);
         diff_ff   <= DiffReset;
         bright_ff <= BrightReset;
      end else if (csr_we) begin
         case (pmo_reg_type'(csr_index))
            RegWidth:  width_ff  <= csr_wdata[DimBits-1:0];
            RegHeight: height_ff <= csr_wdata[DimBits-1:0];
            RegMode:   mode_ff   <= csr_wdata[1:0];
            RegDiff:   diff_ff   <= csr_wdata[7:0];
            RegBright: bright_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         col_ff    <= '0;
         s1_ff.vld <= 1'b0;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         s1_ff.vld <= s1_in.vld;
      end
      s1_ff.row <= s1_in.row;
      s1_ff.col <= s1_in.col;
      s1_ff.nxt <= s1_in.nxt;
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   pmo_raw_mask u_raw (
      .pixel            (pix_ff),
      .in_frame         (s1_in_frame),
      .mask_mode        (mode_ff),
      .diff_threshold   (diff_ff),
      .bright_threshold (bright_ff),
      .raw              (s1_raw)
   );

   pmo_morph u_morph (
      .clock   (clock),
      .reset   (reset),
      .s1      (s1_ff),
      .s1_raw  (s1_raw),
      .width   (width),
      .height  (height),
      .s2_busy (s2_busy),
      .result  (result)
   );

   pmo_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .head      (head),
      .count     (fifo_cnt)
   );

   assign rsp_tdata = {7'd0, head.out_col, head.out_row, head.mask_on};
   assign rsp_tlast = head.frame_last;

endmodule

FILE: src/pmo_raw_mask.sv
// Raw mask bit of one pixel: gray conversion of both frames and mode select.
// Depends on pmo_pkg.
module pmo_raw_mask (
   input  pmo_pkg::pmo_pixel_type pixel,
   input  logic                   in_frame,
   input  logic [1:0]             mask_mode,
   input  logic [7:0]             diff_threshold,
   input  logic [7:0]             bright_threshold,
   output logic                   raw
);
   import pmo_pkg::*;

   logic [7:0] gray_cur;
   logic [7:0] gray_prev;
   logic [8:0] drop;

   always_comb begin
      gray_cur  = pmo_gray(pixel.cur_red, pixel.cur_green, pixel.cur_blue);
      gray_prev = pmo_gray(pixel.prev_red, pixel.prev_green, pixel.prev_blue);
      drop      = {1'b0, gray_prev} - {1'b0, gray_cur};
      raw       = 1'b0;
      if (in_frame) begin
         case (pmo_mode_type'(mask_mode))
            ModeDrop: begin
               raw = (gray_prev > gray_cur) && (drop[7:0] > diff_threshold);
            end
            ModeBright: begin
               raw = gray_cur > bright_threshold;
            end
            ModeGated: begin
               raw = pixel.motion_gate && (gray_cur > bright_threshold);
            end
            default: begin
               raw = 1'b0;
            end
         endcase
      end
   end

endmodule

FILE: src/pmo_morph.sv
// Line memory with read-modify-write of both mask rows, 3x3 cross erosion and
// dilation of one pixel per cycle. Depends on pmo_pkg.
module pmo_morph (
   input  logic                        clock,
   input  logic                        reset,
   input  pmo_pkg::pmo_pos_type        s1,
   input  logic                        s1_raw,
   input  logic [pmo_pkg::DimBits-1:0] width,
   input  logic [pmo_pkg::DimBits-1:0] height,
   output logic                        s2_busy,
   output pmo_pkg::pmo_result_type     result
);
   import pmo_pkg::*;

   pmo_entry_type line_mem [MaxWidth];

   pmo_pos_type   s2_ff;
   logic          raw_ff;
   pmo_entry_type rd_q_ff;
   logic          fwd_hit_ff;
   pmo_entry_type fwd_data_ff;
   pmo_entry_type ctr_ff;
   pmo_entry_type ctr_in;
   logic          win_raw_ff;
   logic          win_ero_ff;

   pmo_entry_type rgt;
   pmo_entry_type wdata;
   logic          ero;
   logic          dil;
   logic          has_left;
   logic          has_right;
   logic [RowBits-1:0] row_ext_h;
   logic [RowBits-1:0] row_m2;

   always_comb begin
      row_ext_h = RowBits'(height);
      has_left  = s2_ff.col != '0;
      has_right = ({1'b0, s2_ff.col} + 1'b1) < width;
      rgt       = fwd_hit_ff ? fwd_data_ff : rd_q_ff;

      ero = 1'b0;
      if (s2_ff.row >= RowBits'(1) && s2_ff.row <= row_ext_h) begin
         ero = ctr_ff.raw_lo;
         if (s2_ff.row >= RowBits'(2)) ero = ero & ctr_ff.raw_up;
         if (s2_ff.row < row_ext_h) ero = ero & raw_ff;
         if (has_left) ero = ero & win_raw_ff;
         if (has_right) ero = ero & rgt.raw_lo;
      end

      dil = ctr_ff.ero_lo;
      if (s2_ff.row >= RowBits'(3)) dil = dil | ctr_ff.ero_up;
      if (s2_ff.row <= row_ext_h) dil = dil | ero;
      if (has_left) dil = dil | win_ero_ff;
      if (has_right) dil = dil | rgt.ero_lo;

      wdata = '{raw_up: ctr_ff.raw_lo, raw_lo: raw_ff, ero_up: ctr_ff.ero_lo, ero_lo: ero};
      // with a one-pixel row the next center is the entry written right now
      ctr_in = (s2_ff.nxt == s2_ff.col) ? wdata : rgt;

      row_m2              = s2_ff.row - RowBits'(2);
      result.vld          = s2_ff.vld && (s2_ff.row >= RowBits'(2));
      result.mask_on      = dil;
      result.out_row      = row_m2[7:0];
      result.out_col      = s2_ff.col[7:0];
      result.frame_last   = (s2_ff.row == row_ext_h + 1'b1) && !has_right;
      s2_busy             = s2_ff.vld;
   end

   always_ff @(posedge clock) begin
      if (s1.vld) begin
         rd_q_ff <= line_mem[s1.nxt];
      end
      if (s2_ff.vld) begin
         line_mem[s2_ff.col] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.vld  <= 1'b0;
         win_raw_ff <= 1'b0;
         win_ero_ff <= 1'b0;
      end else begin
         s2_ff.vld <= s1.vld;
         if (s2_ff.vld) begin
            win_raw_ff <= ctr_ff.raw_lo;
            win_ero_ff <= ctr_ff.ero_lo;
         end
      end
      s2_ff.row <= s1.row;
      s2_ff.col <= s1.col;
      s2_ff.nxt <= s1.nxt;
   end

   always_ff @(posedge clock) begin
      raw_ff      <= s1_raw;
      // forward a write that lands on the entry being read in the same cycle
      fwd_hit_ff  <= s2_ff.vld && (s2_ff.col == s1.nxt);
      fwd_data_ff <= wdata;
      if (s2_ff.vld) begin
         ctr_ff <= ctr_in;
      end
   end

endmodule

FILE: src/pmo_out_fifo.sv
// Small result queue between the pipeline and the response channel.
// Depends on pmo_pkg.
module pmo_out_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  pmo_pkg::pmo_result_type         push,
   input  logic                            pop_ready,
   output logic                            pop_valid,
   output pmo_pkg::pmo_result_type         head,
   output logic [pmo_pkg::FifoCntBits-1:0] count
);
   import pmo_pkg::*;

   pmo_result_type           slot_ff [FifoDepth];
   logic [FifoPtrBits-1:0]   wr_ptr_ff;
   logic [FifoPtrBits-1:0]   rd_ptr_ff;
   logic [FifoCntBits-1:0]   cnt_ff;
   logic                     pop;

   always_comb begin
      pop_valid = cnt_ff != '0;
      head      = slot_ff[rd_ptr_ff];
      pop       = pop_valid && pop_ready;
      count     = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (push.vld) begin
         slot_ff[wr_ptr_ff] <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push.vld) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_ff + FifoCntBits'(push.vld) - FifoCntBits'(pop);
      end
   end

endmodule

FILE: dv/pixel_mask_with_opening_unit_test.sv
// Self-checking bench for pixel_mask_with_opening_unit: streams whole frames of
// pixel requests under many register settings and checks every opened mask bit.
// Depends on pmo_pkg and the RTL of the unit; the expected results come from a
// scoreboard class that models the line buffers and both morphology passes.
module pixel_mask_with_opening_unit_test;
   import pmo_pkg::*;

   localparam int ClockHigh = 4;
   localparam int ClockLow  = 4;
   localparam int ResetCycles = 12;
   localparam int DrainCycles = 8;
   localparam int StallLimit  = 4000;
   localparam int RandomItems = 150;
   localparam logic [1:0] ModeUnused = 2'd3;

   typedef struct {
      bit         mask_on;
      logic [7:0] out_row;
      logic [7:0] out_col;
      bit         frame_last;
   } mask_result_t;

   class mask_scoreboard;
      int width_reg, height_reg, diff_thr, bright_thr;
      logic [1:0] mode_reg;
      bit raw_up[MaxWidth];
      bit raw_lo[MaxWidth];
      bit ero_up[MaxWidth];
      bit ero_lo[MaxWidth];
      bit raw_win, ero_win;
      int in_row, in_col;
      mask_result_t pending_masks[$];
      int errors, checked;

      function new();
         width_reg = 206;
         height_reg = 156;
         mode_reg = ModeDrop;
         diff_thr = 5;
         bright_thr = 200;
         raw_win = 0;
         ero_win = 0;
         in_row = 0;
         in_col = 0;
         errors = 0;
         checked = 0;
      endfunction

      function int eff_width();
         if (width_reg == 0) return 1;
         return (width_reg > MaxWidth) ? MaxWidth : width_reg;
      endfunction

      function int eff_height();
         if (height_reg == 0) return 1;
         return (height_reg > MaxHeight) ? MaxHeight : height_reg;
      endfunction

      function void write_reg(pmo_reg_type idx, int value);
         case (idx)
            RegWidth:  width_reg  = value & 'h1FF;
            RegHeight: height_reg = value & 'h1FF;
            RegMode:   mode_reg   = 2'(value & 'h3);
            RegDiff:   diff_thr   = value & 'hFF;
            RegBright: bright_thr = value & 'hFF;
            default: ;
         endcase
      endfunction

      function int gray_of(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         return (int'(red) * 4899 + int'(green) * 9617 + int'(blue) * 1868 + 8192) >> 14;
      endfunction

      function void note_request(logic [55:0] pix, bit pad);
         int w, h, r, c, gc, gp;
         bit raw, ero, dil;
         mask_result_t res;
         w = eff_width();
         h = eff_height();
         raw = 0;
         ero = 0;
         if (in_col >= w || in_row >= h + 2) begin
            in_row = 0;
            in_col = 0;
         end
         r = in_row;
         c = in_col;
         // drop pads inside the image rows
         if (r < h && pad) return;
         if (r < h) begin
            gc = gray_of(pix[7:0], pix[15:8], pix[23:16]);
            gp = gray_of(pix[31:24], pix[39:32], pix[47:40]);
            case (mode_reg)
               ModeDrop:   raw = (gp - gc > diff_thr);
               ModeBright: raw = (gc > bright_thr);
               ModeGated:  raw = pix[48] && (gc > bright_thr);
               default:    raw = 0;
            endcase
         end
         // erode pixel (r-1, c)
         if (r >= 1 && r <= h) begin
            ero = raw_lo[c];
            if (r >= 2) ero &= raw_up[c];
            if (r < h) ero &= raw;
            if (c >= 1) ero &= raw_win;
            if (c + 1 < w) ero &= raw_lo[c+1];
         end
         raw_win = raw_lo[c];
         raw_up[c] = raw_lo[c];
         raw_lo[c] = raw;
         // dilate pixel (r-2, c)
         if (r >= 2) begin
            dil = ero_lo[c];
            if (r >= 3) dil |= ero_up[c];
            if (r <= h) dil |= ero;
            if (c >= 1) dil |= ero_win;
            if (c + 1 < w) dil |= ero_lo[c+1];
            res.mask_on = dil;
            res.out_row = 8'(r - 2);
            res.out_col = 8'(c);
            res.frame_last = (r == h + 1 && c + 1 == w);
            pending_masks.insert(pending_masks.size(), res);
         end
         ero_win = ero_lo[c];
         ero_up[c] = ero_lo[c];
         ero_lo[c] = ero;
         in_col = c + 1;
         if (in_col >= w) begin
            in_col = 0;
            in_row = r + 1;
            if (in_row >= h + 2) in_row = 0;
         end
      endfunction

      function void check_response(logic [23:0] data, logic last);
         mask_result_t res;
         if (pending_masks.size() == 0) begin
            $display("%0t: unexpected response mask=%0b row=%0d col=%0d last=%0b",
                     $time, data[0], data[8:1], data[16:9], last);
            errors++;
            return;
         end
         res = pending_masks.pop_front();
         checked++;
         if (data[0] !== res.mask_on || data[8:1] !== res.out_row ||
             data[16:9] !== res.out_col || last !== res.frame_last) begin
            $display("%0t: mismatch expected mask=%0b row=%0d col=%0d last=%0b",
                     $time, res.mask_on, res.out_row, res.out_col, res.frame_last);
            $display("%0t:          actual   mask=%0b row=%0d col=%0d last=%0b",
                     $time, data[0], data[8:1], data[16:9], last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic                  csr_we = 0;
   logic [CsrIdxBits-1:0] csr_index = '0;
   logic [CsrBits-1:0]    csr_wdata = '0;

   mask_scoreboard sb = new();
   bit quiet = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int pixel_count = 0;
   int frame_count = 0;
   int setting_count = 0;

   pixel_mask_with_opening_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #ClockHigh clock = 1;
      #ClockLow  clock = 0;
   end

   // response side: check and stall in bursts
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("watchdog: no progress for %0d cycles", StallLimit);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] clip(int v);
      return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
   endfunction

   // bias levels toward the thresholds so the mask has both values
   function automatic logic [55:0] make_pixel();
      int lvl, plvl;
      logic [55:0] pix;
      if ($urandom_range(0, 3) == 0) begin
         pix = 56'({$urandom, $urandom});
         pix[55:49] = '0;
         return pix;
      end
      lvl = sb.bright_thr + $urandom_range(0, 40) - 20;
      if ($urandom_range(0, 1) == 0) lvl = $urandom_range(0, 255);
      plvl = lvl + sb.diff_thr + $urandom_range(0, 16) - 8;
      pix = '0;
      pix[7:0]   = clip(lvl + $urandom_range(0, 2) - 1);
      pix[15:8]  = clip(lvl);
      pix[23:16] = clip(lvl + $urandom_range(0, 2) - 1);
      pix[31:24] = clip(plvl);
      pix[39:32] = clip(plvl + $urandom_range(0, 2) - 1);
      pix[47:40] = clip(plvl);
      pix[48]    = 1'($urandom_range(0, 1));
      return pix;
   endfunction

   task automatic send_request(logic [55:0] pix, bit pad);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= pix;
      req_tuser <= pad;
      do @(posedge clock); while (!req_tready);
      sb.note_request(pix, pad);
   endtask

   // pattern: 0 random, 1 checkerboard of black and white, 2 all white
   task automatic send_rows(int rows, int pattern);
      int w, h;
      logic [55:0] pix;
      w = sb.eff_width();
      h = sb.eff_height();
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < w; c++) begin
            if (r < h) begin
               if ($urandom_range(0, 9) == 0) send_request(56'({$urandom, $urandom}), 1);
               case (pattern)
                  1: pix = ((r + c) % 2) ? {8'h01, {6{8'hFF}}} : '0;
                  2: pix = {8'h01, {6{8'hFF}}};
                  default: pix = make_pixel();
               endcase
               send_request(pix, 0);
            end else if ($urandom_range(0, 3) == 0) begin
               // a pixel in the flush rows acts as a pad
               send_request(make_pixel(), 0);
            end else begin
               send_request('0, 1);
            end
            pixel_count++;
         end
      end
   endtask

   task automatic send_frame(int pattern);
      send_rows(sb.eff_height() + 2, pattern);
      frame_count++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      while (sb.pending_masks.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_config(int w, int h, logic [1:0] mode, int diff, int bright);
      csr_we <= 1;
      csr_index <= RegWidth;  csr_wdata <= CsrBits'(w);      @(posedge clock);
      sb.write_reg(RegWidth, w);
      csr_index <= RegHeight; csr_wdata <= CsrBits'(h);      @(posedge clock);
      sb.write_reg(RegHeight, h);
      csr_index <= RegMode;   csr_wdata <= CsrBits'(mode);   @(posedge clock);
      sb.write_reg(RegMode, mode);
      csr_index <= RegDiff;   csr_wdata <= CsrBits'(diff);   @(posedge clock);
      sb.write_reg(RegDiff, diff);
      csr_index <= RegBright; csr_wdata <= CsrBits'(bright); @(posedge clock);
      sb.write_reg(RegBright, bright);
      csr_we <= 0;
      setting_count++;
   endtask

   function automatic int pick_threshold();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   initial begin
      int target, w, h;
      repeat (ResetCycles) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      set_config(3, 3, ModeBright, 0, 127);
      send_frame(1);
      send_frame(2);
      wait_idle();
      set_config(4, 4, ModeDrop, 5, 200);
      send_rows(2, 0);
      send_request(make_pixel(), 0);
      wait_idle();
      // shrink the frame mid-way so the position restarts at the origin
      set_config(1, 4, ModeDrop, 5, 200);
      send_frame(0);
      wait_idle();
      set_config(0, 0, ModeUnused, 255, 255);
      send_frame(2);
      wait_idle();
      set_config(300, 1, ModeGated, 255, 0);
      send_frame(0);
      wait_idle();
      set_config(1, 300, ModeDrop, 0, 255);
      send_frame(0);
      wait_idle();

      target = pixel_count + RandomItems;
      while (pixel_count < target) begin
         if (pixel_count > target - 80) quiet = 1;
         w = $urandom_range(1, 16);
         h = $urandom_range(1, 8);
         if ($urandom_range(0, 9) == 0) w = 0;
         if ($urandom_range(0, 9) == 0) h = 0;
         set_config(w, h, 2'($urandom_range(0, 3)), pick_threshold(), pick_threshold());
         repeat ($urandom_range(1, 3)) send_frame(0);
         wait_idle();
      end

      $display("run: %0d pixel requests in %0d frames over %0d register settings",
               pixel_count, frame_count, setting_count);
      $display("run: %0d mask responses checked, %0d errors", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending_masks.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
